### src/amd_pkg.sv
// Shared types and constants for the accelerometer magnitude motion detector.
// Used by the front end, the queue, the back end, the top level and the checker.
package amd_pkg;

    // Reset value of the motion threshold: 1.5 m/s^2 expressed in mg, Q12.4.
    localparam logic [15:0] THRESHOLD_RESET = 16'd2447;

    // Width of the magnitude, its radicand and the number of root iterations.
    localparam int MAG_W      = 16;
    localparam int RAD_W      = 2 * MAG_W;
    localparam int ROOT_STEPS = MAG_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    // Decoded axis width and the widths of squares and their sum.
    localparam int AXIS_W = 12;
    localparam int SQ_W   = 23;
    localparam int SUM_W  = 24;

    // Largest magnitude that full-scale axes can produce.
    localparam logic [MAG_W-1:0] MAG_MAX = 16'd56755;

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One decoded sample: three signed axis counts in mg.
    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } amd_axes_t;

    // Write side of the queue, driven by the front end.
    typedef struct packed {
        logic      push;
        amd_axes_t axes;
    } amd_push_t;

    // Read side of the queue, seen by the back end.
    typedef struct packed {
        logic      avail;
        amd_axes_t axes;
    } amd_head_t;

endpackage

### src/amd_front.sv
// Front end: accepts raw sample items and decodes the three axis words.
// Depends on amd_pkg for the axis and queue types.
module amd_front
    import amd_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] x_low,
    input  logic [7:0] x_high,
    input  logic [7:0] y_low,
    input  logic [7:0] y_high,
    input  logic [7:0] z_low,
    input  logic [7:0] z_high,
    input  logic       queue_full,
    output amd_push_t  push
);

    // Each axis is a left-aligned 16-bit word; dropping the low nibble
    // leaves the signed 12-bit count directly. An item is taken whenever
    // the queue has room for it.
    always_comb
    begin
        push.push   = in_valid && !queue_full;
        push.axes.x = $signed({x_high, x_low[7:4]});
        push.axes.y = $signed({y_high, y_low[7:4]});
        push.axes.z = $signed({z_high, z_low[7:4]});
    end

    assign in_stall = queue_full;

endmodule

### src/amd_queue.sv
// Short register queue between the front and back ends.
// Depends on amd_pkg for the depth and the entry types.
module amd_queue
    import amd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  amd_push_t push,
    input  logic      pop,
    output logic      full,
    output amd_head_t head
);

    amd_axes_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head.avail = (count_reg != '0);
    assign head.axes  = entry_reg[rd_ptr_reg];

    assign do_push = push.push && !full;
    assign do_pop  = pop && head.avail;

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage holds payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.axes;
        end
    end

endmodule

### src/amd_back.sv
// Back end: squares, sums, takes the iterative square root, compares the
// change against the threshold and holds the result item for the receiver.
// Depends on amd_pkg for widths, constants and the queue head type.
module amd_back
    import amd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wen,
    input  logic [15:0]              cfg_wdata,
    input  amd_head_t                head,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [AXIS_W-1:0] accel_x,
    output logic signed [AXIS_W-1:0] accel_y,
    output logic signed [AXIS_W-1:0] accel_z,
    output logic [MAG_W-1:0]         magnitude_q4,
    output logic [MAG_W-1:0]         change_q4,
    output logic                     motion
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_FINISH
    } state_t;

    state_t                    state_reg;
    amd_axes_t                 axes_reg;
    logic [SQ_W-1:0]           sq_x_reg;
    logic [SQ_W-1:0]           sq_y_reg;
    logic [SQ_W-1:0]           sq_z_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [MAG_W+1:0]          rem_reg;
    logic [MAG_W-1:0]          root_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [MAG_W-1:0]          prev_reg;
    logic [15:0]               thr_reg;
    logic                      out_valid_reg;
    logic signed [AXIS_W-1:0]  accel_x_reg;
    logic signed [AXIS_W-1:0]  accel_y_reg;
    logic signed [AXIS_W-1:0]  accel_z_reg;
    logic [MAG_W-1:0]          mag_out_reg;
    logic [MAG_W-1:0]          change_out_reg;
    logic                      motion_reg;

    logic signed [2*AXIS_W-1:0] prod_x;
    logic signed [2*AXIS_W-1:0] prod_y;
    logic signed [2*AXIS_W-1:0] prod_z;
    logic [SUM_W-1:0]           sum;
    logic [MAG_W+3:0]           rem_trial;
    logic [MAG_W+3:0]           sub_trial;
    logic                       root_bit;
    logic [MAG_W+3:0]           rem_next;
    logic [MAG_W-1:0]           root_next;
    logic [MAG_W-1:0]           change_next;
    logic                       motion_next;
    logic                       out_free;

    // Three squares in parallel, registered before they are added.
    assign prod_x = axes_reg.x * axes_reg.x;
    assign prod_y = axes_reg.y * axes_reg.y;
    assign prod_z = axes_reg.z * axes_reg.z;
    assign sum    = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg) + SUM_W'(sq_z_reg);

    // One digit of the restoring square root: bring down two radicand bits
    // and try to subtract four times the partial root plus one.
    always_comb
    begin
        rem_trial = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        sub_trial = {2'b00, root_reg, 2'b01};
        root_bit  = (rem_trial >= sub_trial);
        rem_next  = root_bit ? (rem_trial - sub_trial) : rem_trial;
        root_next = {root_reg[MAG_W-2:0], root_bit};
    end

    // Absolute change from the previous magnitude and the threshold test.
    always_comb
    begin
        change_next = (root_reg >= prev_reg) ? (root_reg - prev_reg)
                                             : (prev_reg - root_reg);
        motion_next = (change_next > thr_reg);
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == ST_IDLE) && head.avail;

    // Sequencer, working registers and the output holding register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axes_reg       <= '0;
            sq_x_reg       <= '0;
            sq_y_reg       <= '0;
            sq_z_reg       <= '0;
            rad_reg        <= '0;
            rem_reg        <= '0;
            root_reg       <= '0;
            step_reg       <= '0;
            prev_reg       <= '0;
            thr_reg        <= THRESHOLD_RESET;
            out_valid_reg  <= 1'b0;
            accel_x_reg    <= '0;
            accel_y_reg    <= '0;
            accel_z_reg    <= '0;
            mag_out_reg    <= '0;
            change_out_reg <= '0;
            motion_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                thr_reg <= cfg_wdata;
            end

            // The held item leaves when the receiver takes it, unless the
            // finish state loads the next one in its place.
            if (out_valid_reg && !out_stall && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head.avail)
                    begin
                        axes_reg  <= head.axes;
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    sq_x_reg  <= prod_x[SQ_W-1:0];
                    sq_y_reg  <= prod_y[SQ_W-1:0];
                    sq_z_reg  <= prod_z[SQ_W-1:0];
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    rad_reg   <= {sum, 8'h00};
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                    rem_reg  <= rem_next[MAG_W+1:0];
                    root_reg <= root_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(ROOT_STEPS - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        accel_x_reg    <= axes_reg.x;
                        accel_y_reg    <= axes_reg.y;
                        accel_z_reg    <= axes_reg.z;
                        mag_out_reg    <= root_reg;
                        change_out_reg <= change_next;
                        motion_reg     <= motion_next;
                        prev_reg       <= root_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign accel_x      = accel_x_reg;
    assign accel_y      = accel_y_reg;
    assign accel_z      = accel_z_reg;
    assign magnitude_q4 = mag_out_reg;
    assign change_q4    = change_out_reg;
    assign motion       = motion_reg;

endmodule

### src/accel_magnitude_motion_detector_unit.sv
// Accelerometer magnitude motion detector, top level.
// Depends on amd_pkg, amd_front, amd_queue and amd_back.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one item per sample: the
//   six raw output bytes of a three-axis accelerometer. The output channel
//   (out_valid / out_stall) returns one item per input item, in order: the
//   decoded axes in mg, the magnitude in mg Q12.4, its absolute change from
//   the previous sample and the motion flag. The threshold is written through
//   cfg_wen / cfg_wdata while the block is idle.
//   From input acceptance to out_valid, with the back end free, an item is
//   popped from the queue, squared, summed, taken through sixteen iterations
//   of the shared square-root digit unit and loaded into the output register.
//   The back end pops no new item until the current one leaves the finish
//   state, so the square-root loop bounds the throughput.
//   A two-entry queue sits between the front and back ends, so items are
//   accepted while earlier ones are still being worked on. When the receiver
//   stalls, the finished item is held in the output register, the back end
//   waits before loading the next result, and in_stall rises once the queue
//   fills.
//   Reset clears the queue, the output valid, the stored previous magnitude
//   (so the first change equals the magnitude) and loads the threshold 2447.
module accel_magnitude_motion_detector_unit
    import amd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wen,
    input  logic [15:0]              cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               x_low,
    input  logic [7:0]               x_high,
    input  logic [7:0]               y_low,
    input  logic [7:0]               y_high,
    input  logic [7:0]               z_low,
    input  logic [7:0]               z_high,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [AXIS_W-1:0] accel_x,
    output logic signed [AXIS_W-1:0] accel_y,
    output logic signed [AXIS_W-1:0] accel_z,
    output logic [MAG_W-1:0]         magnitude_q4,
    output logic [MAG_W-1:0]         change_q4,
    output logic                     motion
);

    amd_push_t push;
    amd_head_t head;
    logic      queue_full;
    logic      pop;

    // Accept and decode.
    amd_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .x_low      (x_low),
        .x_high     (x_high),
        .y_low      (y_low),
        .y_high     (y_high),
        .z_low      (z_low),
        .z_high     (z_high),
        .queue_full (queue_full),
        .push       (push)
    );

    // Decoupling queue.
    amd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    // Magnitude, change and motion decision.
    amd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .magnitude_q4 (magnitude_q4),
        .change_q4    (change_q4),
        .motion       (motion)
    );

endmodule

### src/amd_checker.sv
// Port-level checks for the accelerometer magnitude motion detector.
// Depends on amd_pkg; bound to accel_magnitude_motion_detector_unit below.
module amd_checker
    import amd_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cfg_wen,
    input logic [15:0]              cfg_wdata,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [AXIS_W-1:0] accel_x,
    input logic signed [AXIS_W-1:0] accel_y,
    input logic signed [AXIS_W-1:0] accel_z,
    input logic [MAG_W-1:0]         magnitude_q4,
    input logic [MAG_W-1:0]         change_q4,
    input logic                     motion
);

    logic [15:0]      thr_reg;
    logic [MAG_W-1:0] prev_reg;
    logic [MAG_W-1:0] exp_change;

    // Shadow copies of the threshold and of the last delivered magnitude.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RESET;
            prev_reg <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                thr_reg <= cfg_wdata;
            end
            if (out_valid && !out_stall)
            begin
                prev_reg <= magnitude_q4;
            end
        end
    end

    assign exp_change = (magnitude_q4 >= prev_reg) ? (magnitude_q4 - prev_reg)
                                                   : (prev_reg - magnitude_q4);

    // A stalled result item stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(accel_x) && $stable(accel_y)
            && $stable(accel_z) && $stable(magnitude_q4) && $stable(change_q4)
            && $stable(motion))
        else $error("result item changed or vanished while stalled");

    // The change is measured against the previously delivered magnitude.
    a_change: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> change_q4 == exp_change)
        else $error("change does not match the previous magnitude");

    // The motion flag follows the current threshold.
    a_motion: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> motion == (change_q4 > thr_reg))
        else $error("motion flag disagrees with the threshold");

    // The magnitude never exceeds the full-scale value.
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> magnitude_q4 <= MAG_MAX)
        else $error("magnitude beyond full scale");

endmodule

bind accel_magnitude_motion_detector_unit amd_checker u_amd_checker (.*);
